### hw/rtl/nnbs_pkg.sv
// ---------------------------------------------------------------------------
// nnbs_pkg: shared types and constants
// Scale modes, result kinds, register indexes and the divide-by-five helper
// used by the band scaler and its histogram store.
// ---------------------------------------------------------------------------
`default_nettype none

package nnbs_pkg;

  localparam int BAND_ROWS = 20;
  localparam int OUT_WIDTH = 256;
  localparam int BIN_W     = 8;
  localparam int COUNT_W   = 16;
  localparam int BINS      = 1 << BIN_W;

  // Scale factors in tenths for each supported crop width.
  localparam int S_640 = 4;
  localparam int S_320 = 8;
  localparam int S_512 = 5;
  localparam int S_256 = 10;

  localparam logic [10:0] WIDTH_640 = 11'd640;
  localparam logic [10:0] WIDTH_320 = 11'd320;
  localparam logic [10:0] WIDTH_512 = 11'd512;
  localparam logic [10:0] WIDTH_256 = 11'd256;

  localparam logic [9:0] LAST_OFS_512 = 10'd380;
  localparam logic [9:0] LAST_OFS_256 = 10'd180;

  localparam logic [4:0] ROWS_640      = 5'(BAND_ROWS * S_640 / 10);
  localparam logic [4:0] ROWS_320      = 5'(BAND_ROWS * S_320 / 10);
  localparam logic [4:0] ROWS_512      = 5'(BAND_ROWS * S_512 / 10);
  localparam logic [4:0] ROWS_256      = 5'(BAND_ROWS * S_256 / 10);
  localparam logic [4:0] LAST_ROWS_512 = 5'd2;
  localparam logic [4:0] LAST_ROWS_256 = 5'd12;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] REG_CROP_LEFT  = 2'd0;
  localparam logic [1:0] REG_CROP_RIGHT = 2'd1;
  localparam logic [1:0] REG_CROP_TOP   = 2'd2;
  localparam logic [1:0] REG_HALF_RES   = 2'd3;

  typedef enum logic [1:0] {
    RK_PIXEL = 2'd0,
    RK_COUNT = 2'd1,
    RK_ERROR = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    MODE_BAD = 3'd0,
    MODE_640 = 3'd1,
    MODE_320 = 3'd2,
    MODE_512 = 3'd3,
    MODE_256 = 3'd4
  } scale_mode_t;

  // Update request from the last pipeline stage to the histogram store.
  typedef struct packed {
    logic             wr;
    logic [BIN_W-1:0] addr;
  } hist_upd_t;

  // floor(v / 5) by reciprocal multiply; exact for every 10-bit v.
  function automatic logic [7:0] div5(input logic [9:0] v);
    logic [17:0] prod;
    prod = v * 8'd205;
    return prod[17:10];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/nnbs_chan_if.sv
// ---------------------------------------------------------------------------
// nnbs_in_if / nnbs_out_if: valid/ready channels of the band scaler
// Source pixels and bin reads enter on nnbs_in_if; results leave on
// nnbs_out_if.
// ---------------------------------------------------------------------------
`default_nettype none

interface nnbs_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] pixel_value;
  logic [9:0] source_column;
  logic [4:0] band_row;
  logic [8:0] band_line;
  logic [7:0] bin_index;

  modport source (output valid, opcode, pixel_value, source_column, band_row,
                  band_line, bin_index, input ready);
  modport sink (input valid, opcode, pixel_value, source_column, band_row,
                band_line, bin_index, output ready);
endinterface

interface nnbs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] result_value;
  logic [7:0]  out_column;
  logic [4:0]  out_row;

  modport source (output valid, result_kind, result_value, out_column, out_row,
                  input ready);
  modport sink (input valid, result_kind, result_value, out_column, out_row,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/nearest_neighbor_band_scaler.sv
// ---------------------------------------------------------------------------
// nearest_neighbor_band_scaler: nearest-neighbor band downscaler
// Selects source pixels of a horizontal band for a 4, 5, 8 or 10 tenths
// scale set by the crop width, and keeps a 256-bin histogram of them.
// ---------------------------------------------------------------------------
// Usage:
// The in_chan channel carries one beat per source pixel (opcode 0) or per
// histogram bin read (opcode 1). Each beat gives at most one beat on out_chan:
// a scaled pixel with its output column and row, a bin count, or an error
// kind when the crop width is not supported. Unselected pixels give no beat.
// The crop registers sit on the APB port; the user must write them only
// while idle, as the block does not enforce it. Throughput is one beat per
// cycle unless a result waits behind a stalled out_chan. The pace is set by
// the histogram memory, read in one stage and written back in the next with
// a bypass for repeated bins, so one read and one write per cycle.
// Reset restores the crop registers and empties the pipeline. The histogram
// reads as all zero at once through per-bin valid bits; no clearing pass.
// When out_chan stalls, the input keeps being taken while the pipeline holds
// beats that produce no result; in_chan.ready drops only when a result is
// waiting behind the stalled output register.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_band_scaler
  import nnbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  nnbs_in_if.sink          in_chan,
  nnbs_out_if.source       out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Configuration registers.
  logic [9:0] crop_left_r;
  logic [9:0] crop_right_r;
  logic [8:0] crop_top_r;
  logic       half_res_r;

  logic [9:0] left_eff;
  logic [9:0] right_eff;
  logic [9:0] top_eff;

  // Pipeline control.
  logic en;
  logic in_fire;

  // Stage A.
  logic       a_valid_r;
  logic       a_op_r;
  logic [7:0] a_pix_r;
  logic [7:0] a_bin_r;
  logic [9:0] a_pos_r;
  logic       a_neg_r;
  logic [4:0] a_brow_r;
  logic [8:0] a_bline_r;
  logic [10:0] col_diff;
  logic [10:0] width_w;
  scale_mode_t mode_nxt;
  logic        last_nxt;
  logic [7:0]  qc_nxt;
  logic [7:0]  qr_full;

  // Stage B.
  logic        b_valid_r;
  logic        b_op_r;
  logic [7:0]  b_pix_r;
  logic [7:0]  b_bin_r;
  logic [9:0]  b_pos_r;
  logic        b_neg_r;
  logic [7:0]  b_qc_r;
  logic [4:0]  b_brow_r;
  logic [2:0]  b_qr_r;
  scale_mode_t b_mode_r;
  logic        b_last_r;
  logic [2:0]  rc;
  logic [2:0]  rr;
  logic        col_ok;
  logic        row_ok;
  logic [9:0]  cidx;
  logic [4:0]  ridx;
  logic [4:0]  height;
  logic        hit;
  logic        res_nxt;
  result_kind_t kind_nxt;
  logic [7:0]  rd_addr;

  // Stage C.
  logic         c_valid_r;
  logic         c_res_r;
  logic         c_wr_r;
  result_kind_t c_kind_r;
  logic [7:0]   c_pix_r;
  logic [7:0]   c_col_r;
  logic [4:0]   c_row_r;
  hist_upd_t    upd;
  logic [15:0]  count;
  logic [15:0]  value_nxt;

  // Output register.
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [15:0] out_value_r;
  logic [7:0]  out_col_r;
  logic [4:0]  out_row_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_left_r  <= 10'd0;
      crop_right_r <= 10'd640;
      crop_top_r   <= 9'd0;
      half_res_r   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CROP_LEFT:  crop_left_r  <= pwdata[9:0];
        REG_CROP_RIGHT: crop_right_r <= pwdata[9:0];
        REG_CROP_TOP:   crop_top_r   <= pwdata[8:0];
        REG_HALF_RES:   half_res_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CROP_LEFT:  prdata = {22'd0, crop_left_r};
      REG_CROP_RIGHT: prdata = {22'd0, crop_right_r};
      REG_CROP_TOP:   prdata = {23'd0, crop_top_r};
      REG_HALF_RES:   prdata = {31'd0, half_res_r};
      default:        prdata = '0;
    endcase
  end

  // Half-resolution sources use halved crop edges.
  assign left_eff  = half_res_r ? {1'b0, crop_left_r[9:1]} : crop_left_r;
  assign right_eff = half_res_r ? {1'b0, crop_right_r[9:1]} : crop_right_r;
  assign top_eff   = half_res_r ? {2'b00, crop_top_r[8:1]} : {1'b0, crop_top_r};

  // ---------------- pipeline control ----------------
  // Only a result stuck behind a stalled output register holds the pipeline.
  assign en            = !(out_valid_r && !out_chan.ready && c_valid_r && c_res_r);
  assign in_chan.ready = en;
  assign in_fire       = in_chan.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_fire;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  // ---------------- input capture ----------------
  assign col_diff = {1'b0, in_chan.source_column} - {1'b0, left_eff};

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r    <= in_chan.opcode;
      a_pix_r   <= in_chan.pixel_value;
      a_bin_r   <= in_chan.bin_index;
      a_pos_r   <= col_diff[9:0];
      a_neg_r   <= col_diff[10];
      a_brow_r  <= in_chan.band_row;
      a_bline_r <= in_chan.band_line;
    end
  end

  // ---------------- stage A: scale mode and quotients ----------------
  // A right edge left of the left edge sets bit 10 and matches no width.
  assign width_w = {1'b0, right_eff} - {1'b0, left_eff};

  always_comb begin
    case (width_w)
      WIDTH_640: mode_nxt = MODE_640;
      WIDTH_320: mode_nxt = MODE_320;
      WIDTH_512: mode_nxt = MODE_512;
      WIDTH_256: mode_nxt = MODE_256;
      default:   mode_nxt = MODE_BAD;
    endcase
  end

  assign last_nxt = ((mode_nxt == MODE_512) && ({1'b0, a_bline_r} == top_eff + LAST_OFS_512)) ||
                    ((mode_nxt == MODE_256) && ({1'b0, a_bline_r} == top_eff + LAST_OFS_256));

  assign qc_nxt  = div5(a_pos_r);
  assign qr_full = div5({5'd0, a_brow_r});

  always_ff @(posedge clk) begin
    if (en) begin
      b_op_r   <= a_op_r;
      b_pix_r  <= a_pix_r;
      b_bin_r  <= a_bin_r;
      b_pos_r  <= a_pos_r;
      b_neg_r  <= a_neg_r;
      b_qc_r   <= qc_nxt;
      b_brow_r <= a_brow_r;
      b_qr_r   <= qr_full[2:0];
      b_mode_r <= mode_nxt;
      b_last_r <= last_nxt;
    end
  end

  // ---------------- stage B: selection ----------------
  // Remainders mod 5 only need the low three bits of pos - 5q.
  assign rc = b_pos_r[2:0] - ({b_qc_r[0], 2'b00} + b_qc_r[2:0]);
  assign rr = b_brow_r[2:0] - ({b_qr_r[0], 2'b00} + b_qr_r);

  // Selected positions are floor(k*10/s); per scale they form fixed
  // residue patterns mod 5 (or mod 2), which give k directly.
  always_comb begin
    case (b_mode_r)
      MODE_640: begin
        col_ok = rc inside {3'd0, 3'd2};
        cidx   = {1'b0, b_qc_r, (rc == 3'd2)};
        row_ok = rr inside {3'd0, 3'd2};
        ridx   = {1'b0, b_qr_r, (rr == 3'd2)};
        height = ROWS_640;
      end
      MODE_320: begin
        col_ok = (rc != 3'd4);
        cidx   = {b_qc_r, rc[1:0]};
        row_ok = (rr != 3'd4);
        ridx   = {b_qr_r, rr[1:0]};
        height = ROWS_320;
      end
      MODE_512: begin
        col_ok = !b_pos_r[0];
        cidx   = {1'b0, b_pos_r[9:1]};
        row_ok = !b_brow_r[0];
        ridx   = {1'b0, b_brow_r[4:1]};
        height = b_last_r ? LAST_ROWS_512 : ROWS_512;
      end
      MODE_256: begin
        col_ok = 1'b1;
        cidx   = b_pos_r;
        row_ok = 1'b1;
        ridx   = b_brow_r;
        height = b_last_r ? LAST_ROWS_256 : ROWS_256;
      end
      default: begin
        col_ok = 1'b0;
        cidx   = '0;
        row_ok = 1'b0;
        ridx   = '0;
        height = '0;
      end
    endcase
  end

  assign hit = (b_op_r == OP_PIXEL) && (b_mode_r != MODE_BAD) && !b_neg_r &&
               col_ok && (cidx < 10'(OUT_WIDTH)) && row_ok && (ridx < height);

  always_comb begin
    if (b_op_r == OP_READ) begin
      kind_nxt = RK_COUNT;
    end else if (b_mode_r == MODE_BAD) begin
      kind_nxt = RK_ERROR;
    end else begin
      kind_nxt = RK_PIXEL;
    end
  end

  assign res_nxt = (b_op_r == OP_READ) || (b_mode_r == MODE_BAD) || hit;
  assign rd_addr = (b_op_r == OP_READ) ? b_bin_r : b_pix_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_res_r  <= res_nxt;
      c_wr_r   <= hit;
      c_kind_r <= kind_nxt;
      c_pix_r  <= b_pix_r;
      c_col_r  <= hit ? cidx[7:0] : 8'd0;
      c_row_r  <= hit ? ridx : 5'd0;
    end
  end

  // ---------------- stage C: histogram and result ----------------
  assign upd.wr   = c_valid_r && c_wr_r;
  assign upd.addr = c_pix_r;

  nnbs_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .rd_addr (rd_addr),
    .upd     (upd),
    .count   (count)
  );

  always_comb begin
    case (c_kind_r)
      RK_PIXEL: value_nxt = {8'd0, c_pix_r};
      RK_COUNT: value_nxt = count;
      default:  value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && c_valid_r && c_res_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && c_valid_r && c_res_r) begin
      out_kind_r  <= c_kind_r;
      out_value_r <= value_nxt;
      out_col_r   <= c_col_r;
      out_row_r   <= c_row_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_kind  = out_kind_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.out_column   = out_col_r;
  assign out_chan.out_row      = out_row_r;

  // ---------------- checks ----------------
  a_ready_only_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_valid_r && !out_chan.ready))
    else $error("input stalled without a blocked result");

  a_result_reaches_output : assert property (@(posedge clk) disable iff (!rst_n)
    (en && c_valid_r && c_res_r) |=> out_valid_r)
    else $error("result lost between last stage and output register");

  a_coords_only_on_pixel : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r != RK_PIXEL)) |-> ((out_col_r == 8'd0) && (out_row_r == 5'd0)))
    else $error("coordinates on a non-pixel result");

  a_update_only_for_pixel : assert property (@(posedge clk) disable iff (!rst_n)
    upd.wr |-> (c_kind_r == RK_PIXEL) && c_res_r)
    else $error("histogram update without a scaled pixel");

endmodule

`default_nettype wire

### hw/rtl/nnbs_hist.sv
// ---------------------------------------------------------------------------
// nnbs_hist: histogram bin store with read-modify-write
// A 256 x 16 synchronous memory read one stage ahead of the update, with
// per-entry valid bits for the cleared state and a bypass for back-to-back
// updates of the same bin.
// ---------------------------------------------------------------------------
`default_nettype none

module nnbs_hist
  import nnbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic [BIN_W-1:0]   rd_addr,
  input  wire hist_upd_t          upd,
  output logic      [COUNT_W-1:0] count
);

  logic [COUNT_W-1:0] mem [BINS];
  logic [BINS-1:0]    vld_r;
  logic [COUNT_W-1:0] q_r;
  logic               q_vld_r;
  logic               fwd_r;
  logic [COUNT_W-1:0] fwd_val_r;
  logic [COUNT_W-1:0] new_count;

  // A bin never written since reset reads as zero.
  assign count     = fwd_r ? fwd_val_r : (q_vld_r ? q_r : '0);
  assign new_count = count + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= mem[rd_addr];
      if (upd.wr) begin
        mem[upd.addr] <= new_count;
      end
    end
  end

  // The memory returns the old value when the same bin is written at the
  // edge it is read, so the fresh count is bypassed.
  always_ff @(posedge clk) begin
    if (en) begin
      fwd_val_r <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else if (en) begin
      q_vld_r <= vld_r[rd_addr];
      fwd_r   <= upd.wr && (upd.addr == rd_addr);
      if (upd.wr) begin
        vld_r[upd.addr] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
